// ===== sv/psls_pkg.sv =====
`timescale 1ns / 1ps

package psls_pkg;

  localparam int SEC_W    = 32;
  localparam int MICROS_W = 20;
  localparam int SEQ_W    = 32;
  localparam int LIMIT_W  = 32;
  localparam int LOST_W   = 32;
  localparam int MEAN_W   = 40;
  localparam int SPAN_W   = 55;  // signed (33-bit secs diff * 1e6) + micros diff

  localparam logic signed [MICROS_W:0] MICROS_PER_SEC = 21'sd1000000;
  localparam logic [LIMIT_W-1:0]       LIMIT_RESET    = 32'd10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic capture;   // latch a record beat, form spacing and gap terms
    logic update;    // fold the latched record into the stream state
    logic load;      // start the mean division, clear the stream state
    logic div_step;  // one quotient bit
    logic publish;   // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic last;      // latched record closes the stream
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// ===== sv/probe_spacing_loss_stats_top.sv =====
`timescale 1ns / 1ps
// Probe spacing and loss statistics.
// Input stream: one beat per probe record. in_tdata carries capture seconds,
// microseconds and sequence number; in_tlast closes the stream (run).
// A pair of records that skips forward adds its sequence gap to the lost
// count. A pair that broke sequence or has spacing under the limit adds its
// spacing to a sum. A sequence that does not advance marks the run bad and
// the rest of the run is ignored, bar its closing beat.
// Config: cfg_data written on cfg_valid (cfg_ready is always high) sets the
// spacing limit in microseconds; write only while the block is idle.
// Each record is taken in an accept step that also forms the spacing with a
// multiply-add, then folded in by an update step that takes no record.
// The closing record adds a restoring divide for the mean, one quotient bit a
// cycle: 32 + clog2(MAX_PROBES+1) + MEAN_FRACTION_BITS steps (51 by default),
// then the result moves to the output register once it is free; no records
// are taken meanwhile.
// Output: one beat per stream, held in a register. If the receiver stalls,
// the next stream's records are still taken; only a second result waits.
// Reset (rst_n low, synchronous) clears the stream state, drops out_tvalid
// and returns the limit to 10000 us.
module probe_spacing_loss_stats_top #(
  parameter int MAX_PROBES         = 1024,
  parameter int MEAN_FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [31:0] stamp_seconds, [51:32] stamp_micros, [83:52] probe_sequence
  input  logic [87:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tlast,   // last_probe
  // out_tdata: mean_spacing_x256, used_count, lost_count, zero fill
  output logic [((psls_pkg::MEAN_W + $clog2(MAX_PROBES + 1) + psls_pkg::LOST_W + 7) / 8) * 8 - 1:0]
                      out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // stream_ok
  input  logic [31:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  import psls_pkg::*;

  localparam int CNT_W   = $clog2(MAX_PROBES + 1);
  localparam int OUT_W   = ((MEAN_W + CNT_W + LOST_W + 7) / 8) * 8;

  cmd_t    cmd;
  status_t status;

  logic [MEAN_W-1:0] mean;
  logic [CNT_W-1:0]  used;
  logic [LOST_W-1:0] lost;

  assign cfg_ready = 1'b1;

  psls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  psls_dp #(
    .MAX_PROBES         (MAX_PROBES),
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_valid),
    .cfg_data          (cfg_data),
    .stamp_seconds     (in_tdata[31:0]),
    .stamp_micros      (in_tdata[51:32]),
    .probe_sequence    (in_tdata[83:52]),
    .last_probe        (in_tlast),
    .out_ready         (out_tready),
    .out_valid         (out_tvalid),
    .mean_spacing_x256 (mean),
    .used_count        (used),
    .lost_count        (lost),
    .stream_ok         (out_tuser)
  );

  assign out_tdata = OUT_W'({lost, used, mean});

endmodule

// ===== sv/psls_ctrl.sv =====
`timescale 1ns / 1ps

module psls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psls_pkg::status_t status,
  output psls_pkg::cmd_t    cmd
);
  import psls_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = status.last ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/psls_dp.sv =====
`timescale 1ns / 1ps

module psls_dp #(
  parameter int MAX_PROBES         = 1024,
  parameter int MEAN_FRACTION_BITS = 8,
  localparam int CNT_W             = $clog2(MAX_PROBES + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  psls_pkg::cmd_t                  cmd,
  output psls_pkg::status_t               status,
  input  logic                            cfg_we,
  input  logic [psls_pkg::LIMIT_W-1:0]    cfg_data,
  input  logic [psls_pkg::SEC_W-1:0]      stamp_seconds,
  input  logic [psls_pkg::MICROS_W-1:0]   stamp_micros,
  input  logic [psls_pkg::SEQ_W-1:0]      probe_sequence,
  input  logic                            last_probe,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [psls_pkg::MEAN_W-1:0]     mean_spacing_x256,
  output logic [CNT_W-1:0]                used_count,
  output logic [psls_pkg::LOST_W-1:0]     lost_count,
  output logic                            stream_ok
);
  import psls_pkg::*;

  localparam int SUM_W  = SEC_W + CNT_W;
  localparam int DIV_W  = SUM_W + MEAN_FRACTION_BITS;
  localparam int STEP_W = $clog2(DIV_W + 1);
  localparam int QX_W   = (DIV_W > MEAN_W) ? DIV_W : MEAN_W;

  // configuration
  logic [LIMIT_W-1:0] limit_r;

  // stream state
  logic [SEC_W-1:0]    prev_sec_r;
  logic [MICROS_W-1:0] prev_usec_r;
  logic [SEQ_W-1:0]    prev_seq_r;
  logic                have_prev_r;
  logic                reorder_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    count_r;
  logic [LOST_W-1:0]   gap_total_r;

  // latched record and its precomputed terms
  logic [SEC_W-1:0]        cur_sec_r;
  logic [MICROS_W-1:0]     cur_usec_r;
  logic [SEQ_W-1:0]        cur_seq_r;
  logic                    last_r;
  logic signed [SPAN_W-1:0] span_r;
  logic                    broken_r;
  logic                    fwd_r;
  logic [SEQ_W-1:0]        gap_r;

  // divider and result hold
  logic [DIV_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              elig_r;
  logic [CNT_W-1:0]  res_used_r;
  logic [LOST_W-1:0] res_lost_r;
  logic              res_ok_r;

  logic              out_valid_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [CNT_W-1:0]  out_used_r;
  logic [LOST_W-1:0] out_lost_r;
  logic              out_ok_r;

  // capture-side arithmetic
  logic signed [SEC_W:0]    sec_diff;
  logic signed [MICROS_W:0] usec_diff;
  logic signed [SPAN_W-1:0] span_nxt;
  logic [SEQ_W-1:0]         seq_succ;

  assign sec_diff  = $signed({1'b0, stamp_seconds}) - $signed({1'b0, prev_sec_r});
  assign usec_diff = $signed({1'b0, stamp_micros}) - $signed({1'b0, prev_usec_r});
  assign span_nxt  = SPAN_W'(sec_diff) * SPAN_W'(MICROS_PER_SEC) + SPAN_W'(usec_diff);
  assign seq_succ  = prev_seq_r + SEQ_W'(1);

  // update-side arithmetic
  logic [31:0]       spacing;
  logic              take;
  logic [LOST_W:0]   gap_sum;

  always_comb begin
    if (span_r < 0) begin
      spacing = '0;
    end else if (span_r[SPAN_W-1:32] != '0) begin
      spacing = '1;
    end else begin
      spacing = span_r[31:0];
    end
  end

  assign take    = (broken_r || (spacing < limit_r)) && (count_r < CNT_W'(MAX_PROBES));
  assign gap_sum = {1'b0, gap_total_r} + {1'b0, gap_r};

  // divider step
  logic [CNT_W:0]   trial;
  logic             trial_ge;
  logic [CNT_W:0]   trial_sub;
  logic [QX_W-1:0]  quo_ext;
  logic [MEAN_W-1:0] mean_sat;

  assign trial     = {rem_r, quo_r[DIV_W-1]};
  assign trial_ge  = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign quo_ext   = QX_W'(quo_r);
  assign mean_sat  = ((quo_ext >> MEAN_W) != '0) ? '1 : quo_ext[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      prev_sec_r  <= '0;
      prev_usec_r <= '0;
      prev_seq_r  <= '0;
      have_prev_r <= 1'b0;
      reorder_r   <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      gap_total_r <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end

      if (cmd.update && !reorder_r) begin
        if (have_prev_r) begin
          if (broken_r) begin
            if (fwd_r) begin
              gap_total_r <= gap_sum[LOST_W] ? '1 : gap_sum[LOST_W-1:0];
            end else begin
              reorder_r <= 1'b1;
            end
          end
          if (take) begin
            sum_r   <= sum_r + SUM_W'(spacing);
            count_r <= count_r + CNT_W'(1);
          end
        end
        prev_sec_r  <= cur_sec_r;
        prev_usec_r <= cur_usec_r;
        prev_seq_r  <= cur_seq_r;
        have_prev_r <= 1'b1;
      end

      if (cmd.load) begin
        prev_sec_r  <= '0;
        prev_usec_r <= '0;
        prev_seq_r  <= '0;
        have_prev_r <= 1'b0;
        reorder_r   <= 1'b0;
        sum_r       <= '0;
        count_r     <= '0;
        gap_total_r <= '0;
        step_r      <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + STEP_W'(1);
      end

      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_sec_r  <= stamp_seconds;
      cur_usec_r <= stamp_micros;
      cur_seq_r  <= probe_sequence;
      last_r     <= last_probe;
      span_r     <= span_nxt;
      broken_r   <= probe_sequence != seq_succ;
      fwd_r      <= probe_sequence > prev_seq_r;
      gap_r      <= probe_sequence - prev_seq_r;
    end

    if (cmd.load) begin
      quo_r      <= DIV_W'(sum_r) << MEAN_FRACTION_BITS;
      rem_r      <= '0;
      dvs_r      <= count_r;
      elig_r     <= !reorder_r && (count_r > CNT_W'(1));
      res_used_r <= count_r;
      res_lost_r <= gap_total_r;
      res_ok_r   <= !reorder_r;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], trial_ge};
    end

    if (cmd.publish) begin
      out_mean_r <= elig_r ? mean_sat : '0;
      out_used_r <= res_used_r;
      out_lost_r <= res_lost_r;
      out_ok_r   <= res_ok_r;
    end
  end

  assign status.last     = last_r;
  assign status.div_done = step_r == STEP_W'(DIV_W);
  assign status.out_busy = out_valid_r;

  assign out_valid         = out_valid_r;
  assign mean_spacing_x256 = out_mean_r;
  assign used_count        = out_used_r;
  assign lost_count        = out_lost_r;
  assign stream_ok         = out_ok_r;

endmodule

// ===== sv/psls_chk.sv =====
`timescale 1ns / 1ps

module psls_chk #(
  parameter int MAX_PROBES = 1024,
  parameter int OUT_W      = 88
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);
  import psls_pkg::*;

  localparam int CNT_W = $clog2(MAX_PROBES + 1);

  logic [CNT_W-1:0]  used;
  logic [MEAN_W-1:0] mean;

  assign used = out_tdata[MEAN_W +: CNT_W];
  assign mean = out_tdata[MEAN_W-1:0];

  // every record beat is followed by an update cycle
  a_update_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("record beat taken in update cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_bad_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> mean == '0)
    else $error("mean reported on reordered stream");

  a_few_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (used < CNT_W'(2)) |-> mean == '0)
    else $error("mean reported with fewer than two spacings");

  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> used <= CNT_W'(MAX_PROBES))
    else $error("used count beyond limit");

endmodule

bind probe_spacing_loss_stats_top psls_chk #(
  .MAX_PROBES (MAX_PROBES),
  .OUT_W      (OUT_W)
) u_psls_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
